// File: rtl/assert_macros.svh
// Assertion helpers: clocked property with asynchronous active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk while rst_n is high.
`define SOA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Check that trig implies cond in the next cycle.
`define SOA_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// File: rtl/soa_pkg.sv
package soa_pkg;

	localparam int SLABS        = 8;
	localparam int MAX_OBJECTS  = 256;
	localparam int SLAB_BYTES   = 4096;
	localparam int HEADER_BYTES = 24;

	localparam int SLAB_W = 3;
	localparam int OBJ_W  = 8;
	localparam int CNT_W  = 9;
	localparam int ADDR_W = 15;
	localparam int SIZE_W = 12;
	localparam int D_W    = SIZE_W + 1;
	localparam int DIV_W  = $clog2(SLAB_BYTES + 1);
	localparam int MEM_AW = SLAB_W + OBJ_W;

	localparam logic [SIZE_W-1:0] OBJ_SIZE_RST = SIZE_W'(64);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;
	localparam logic ST_DONE   = 1'b0;
	localparam logic ST_OOM    = 1'b1;

	typedef struct packed {
		logic cfg_we;
		logic ld_in;
		logic do_free;
		logic scan_step;
		logic decide;
		logic pop;
		logic rdat;
		logic mul;
		logic add;
		logic ld_out;
	} soa_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic scan_last;
		logic oom;
	} soa_stat_t;

endpackage

// File: rtl/soa_div.sv
module soa_div
	import soa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [D_W-1:0]   divisor,
	output logic             busy,
	output logic [CNT_W-1:0] per_slab
);

	localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(SLAB_BYTES);
	localparam int BIT_W = $clog2(DIV_W);

	logic             busy_q;
	logic [BIT_W-1:0] bit_q;
	logic [D_W-1:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [D_W:0]     rem_sh;
	logic             ge;
	logic [D_W:0]     rem_nx;

	assign rem_sh = {rem_q, DIVIDEND[bit_q]};
	assign ge     = rem_sh >= {1'b0, divisor};
	assign rem_nx = ge ? rem_sh - {1'b0, divisor} : rem_sh;

	// one quotient bit per cycle, restart after reset and on each size write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			bit_q  <= BIT_W'(DIV_W - 1);
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			bit_q  <= BIT_W'(DIV_W - 1);
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			quo_q[bit_q] <= ge;
			rem_q        <= rem_nx[D_W-1:0];
			if (bit_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				bit_q <= bit_q - 1'b1;
			end
		end
	end

	assign busy     = busy_q;
	assign per_slab = (quo_q > DIV_W'(MAX_OBJECTS)) ? CNT_W'(MAX_OBJECTS) : quo_q[CNT_W-1:0];

endmodule

// File: rtl/soa_ctrl.sv
module soa_ctrl
	import soa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_cmd,
	output logic      in_ready,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      out_ready,
	output logic      out_valid,
	input  soa_stat_t stat,
	output soa_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FREE   = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_POP    = 4'd4;
	localparam logic [3:0] S_RDAT   = 4'd5;
	localparam logic [3:0] S_MUL    = 4'd6;
	localparam logic [3:0] S_ADD    = 4'd7;
	localparam logic [3:0] S_OUT    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       out_valid_q;
	logic       slot_free;
	logic       in_xfer;

	// a pending size write takes the idle slot before any input transfer
	assign cfg_ready = (state_q == S_IDLE) && !stat.div_busy;
	assign in_ready  = cfg_ready && !cfg_valid;
	assign in_xfer   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.cfg_we    = cfg_valid && cfg_ready;
		cmd.ld_in     = in_xfer;
		state_nx      = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					state_nx = (in_cmd == CMD_FREE) ? S_FREE : S_SCAN;
				end
			end
			S_FREE: begin
				cmd.do_free = 1'b1;
				state_nx    = S_MUL;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_nx = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_nx   = stat.oom ? S_OUT : S_POP;
			end
			S_POP: begin
				cmd.pop  = 1'b1;
				state_nx = S_RDAT;
			end
			S_RDAT: begin
				cmd.rdat = 1'b1;
				state_nx = S_MUL;
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = S_ADD;
			end
			S_ADD: begin
				cmd.add  = 1'b1;
				state_nx = S_OUT;
			end
			S_OUT: begin
				if (slot_free) begin
					cmd.ld_out = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/soa_dp.sv
module soa_dp
	import soa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  soa_cmd_t          cmd,
	output soa_stat_t         stat,
	input  logic [SIZE_W-1:0] cfg_data,
	input  logic [SLAB_W-1:0] in_slab,
	input  logic [OBJ_W-1:0]  in_object,
	output logic              out_status,
	output logic [SLAB_W-1:0] out_slab,
	output logic [OBJ_W-1:0]  out_object,
	output logic [ADDR_W-1:0] out_address
);

	logic [SIZE_W-1:0] size_q;
	logic [D_W-1:0]    dsz;
	logic [CNT_W-1:0]  n;
	logic              div_busy;

	logic              claimed_q [SLABS];
	logic [CNT_W-1:0]  count_q   [SLABS];
	logic [CNT_W-1:0]  low_q     [SLABS];   // entries below this read as their own index
	logic [SLAB_W-1:0] rank_q    [SLABS];
	logic [OBJ_W-1:0]  mem       [SLABS * MAX_OBJECTS];

	logic [SLAB_W-1:0] in_s_q;
	logic [OBJ_W-1:0]  in_o_q;

	logic [SLAB_W-1:0] scan_q;
	logic              pf_q, wf_q;
	logic [SLAB_W-1:0] part_q, whole_q, pr_q, wr_q;

	logic [SLAB_W-1:0] sel_q;
	logic              impl_q;
	logic [OBJ_W-1:0]  idx_q;
	logic [OBJ_W-1:0]  rd_q;

	logic              res_st_q;
	logic [SLAB_W-1:0] res_s_q;
	logic [OBJ_W-1:0]  res_o_q;
	logic [OBJ_W+D_W-1:0] prod_q;
	logic [ADDR_W-1:0] addr_q;

	logic              o_st_q;
	logic [SLAB_W-1:0] o_s_q;
	logic [OBJ_W-1:0]  o_o_q;
	logic [ADDR_W-1:0] o_a_q;

	logic              any_free;
	logic [SLAB_W-1:0] first_free;
	logic [CNT_W-1:0]  sc_cnt;
	logic              cand;
	logic              oom;
	logic              free_ok;
	logic [CNT_W-1:0]  pop_cnt;
	logic              touch_en;
	logic [SLAB_W-1:0] touch_s;
	logic [SLAB_W-1:0] sel_nx;

	assign dsz = D_W'(size_q) + D_W'(HEADER_BYTES);

	soa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.cfg_we),
		.divisor  (dsz),
		.busy     (div_busy),
		.per_slab (n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= OBJ_SIZE_RST;
		end else if (cmd.cfg_we) begin
			size_q <= cfg_data;
		end
	end

	always_comb begin
		any_free   = 1'b0;
		first_free = '0;
		for (int i = SLABS - 1; i >= 0; i--) begin
			if (!claimed_q[i]) begin
				any_free   = 1'b1;
				first_free = SLAB_W'(i);
			end
		end
	end

	assign sc_cnt  = count_q[scan_q];
	assign cand    = claimed_q[scan_q] && (sc_cnt != '0);
	assign oom     = (n == '0) || (!pf_q && !wf_q && !any_free);
	assign free_ok = ({1'b0, in_s_q} < (SLAB_W + 1)'(SLABS)) && claimed_q[in_s_q]
		&& ({1'b0, in_o_q} < n) && (count_q[in_s_q] < n);
	assign pop_cnt = count_q[sel_q] - 1'b1;
	assign sel_nx  = pf_q ? part_q : (wf_q ? whole_q : first_free);

	assign touch_en = cmd.pop || (cmd.do_free && free_ok);
	assign touch_s  = cmd.pop ? sel_q : in_s_q;

	assign stat.div_busy  = div_busy;
	assign stat.scan_last = scan_q == SLAB_W'(SLABS - 1);
	assign stat.oom       = oom;

	// per-slab bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLABS; i++) begin
				claimed_q[i] <= 1'b0;
				count_q[i]   <= '0;
				low_q[i]     <= '0;
				rank_q[i]    <= SLAB_W'(i);
			end
		end else begin
			if (cmd.decide && !oom && !pf_q && !wf_q) begin
				claimed_q[first_free] <= 1'b1;
				count_q[first_free]   <= n;
				low_q[first_free]     <= n;
			end
			if (cmd.pop) begin
				count_q[sel_q] <= pop_cnt;
			end
			if (cmd.do_free && free_ok) begin
				count_q[in_s_q] <= count_q[in_s_q] + 1'b1;
				if (count_q[in_s_q] < low_q[in_s_q]) begin
					low_q[in_s_q] <= count_q[in_s_q];
				end
			end
			if (touch_en) begin
				for (int t = 0; t < SLABS; t++) begin
					if (SLAB_W'(t) == touch_s) begin
						rank_q[t] <= '0;
					end else if (rank_q[t] < rank_q[touch_s]) begin
						rank_q[t] <= rank_q[t] + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_free && free_ok) begin
			mem[{in_s_q, count_q[in_s_q][OBJ_W-1:0]}] <= in_o_q;
		end
		rd_q <= mem[{sel_q, pop_cnt[OBJ_W-1:0]}];
	end

	// scan control: one slab per cycle, keep most recent candidate of each kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			pf_q    <= 1'b0;
			wf_q    <= 1'b0;
			part_q  <= '0;
			whole_q <= '0;
			pr_q    <= '0;
			wr_q    <= '0;
		end else if (cmd.ld_in) begin
			scan_q <= '0;
			pf_q   <= 1'b0;
			wf_q   <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + 1'b1;
			if (cand && (sc_cnt < n)) begin
				if (!pf_q || rank_q[scan_q] < pr_q) begin
					pf_q   <= 1'b1;
					part_q <= scan_q;
					pr_q   <= rank_q[scan_q];
				end
			end else if (cand) begin
				if (!wf_q || rank_q[scan_q] < wr_q) begin
					wf_q    <= 1'b1;
					whole_q <= scan_q;
					wr_q    <= rank_q[scan_q];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			in_s_q <= in_slab;
			in_o_q <= in_object;
		end
		if (cmd.do_free) begin
			res_st_q <= ST_DONE;
			res_s_q  <= in_s_q;
			res_o_q  <= in_o_q;
		end
		if (cmd.decide) begin
			if (oom) begin
				res_st_q <= ST_OOM;
				res_s_q  <= '0;
				res_o_q  <= '0;
				addr_q   <= '0;
			end else begin
				res_st_q <= ST_DONE;
				res_s_q  <= sel_nx;
				sel_q    <= sel_nx;
			end
		end
		if (cmd.pop) begin
			impl_q <= pop_cnt < low_q[sel_q];
			idx_q  <= pop_cnt[OBJ_W-1:0];
		end
		if (cmd.rdat) begin
			res_o_q <= impl_q ? idx_q : rd_q;
		end
		if (cmd.mul) begin
			prod_q <= res_o_q * dsz;
		end
		if (cmd.add) begin
			addr_q <= ADDR_W'(res_s_q) * ADDR_W'(SLAB_BYTES) + ADDR_W'(prod_q)
				+ ADDR_W'(HEADER_BYTES);
		end
		if (cmd.ld_out) begin
			o_st_q <= res_st_q;
			o_s_q  <= res_s_q;
			o_o_q  <= res_o_q;
			o_a_q  <= addr_q;
		end
	end

	assign out_status  = o_st_q;
	assign out_slab    = o_s_q;
	assign out_object  = o_o_q;
	assign out_address = o_a_q;

endmodule

// File: rtl/slab_object_allocator_unit.sv
// Slab object allocator over 8 slabs of 4096 bytes. Send an allocate (tuser 0) or a free
// (tuser 1, with slab and object in tdata); each transfer returns one result. An allocate
// runs a scan of the slab table at one slab per cycle followed by a free-stack memory read
// and the address multiply. After reset and after each object_size write the objects-per-slab
// divider runs, during which neither channel is ready. A finished result waits in an output
// register while the next item is taken in.
`include "assert_macros.svh"

module slab_object_allocator_unit
	import soa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // slab_index[2:0], object_index[10:3]
	input  logic        s_axis_tuser,   // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // out_slab[2:0], out_object[10:3], object_address[25:11]
	output logic        m_axis_tuser,   // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data
);

	soa_cmd_t          cmd;
	soa_stat_t         stat;
	logic [SLAB_W-1:0] o_slab;
	logic [OBJ_W-1:0]  o_obj;
	logic [ADDR_W-1:0] o_addr;
	logic              in_xfer;
	logic              oom_out;

	soa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.stat      (stat),
		.cmd       (cmd)
	);

	soa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_data    (cfg_data),
		.in_slab     (s_axis_tdata[SLAB_W-1:0]),
		.in_object   (s_axis_tdata[SLAB_W+OBJ_W-1:SLAB_W]),
		.out_status  (m_axis_tuser),
		.out_slab    (o_slab),
		.out_object  (o_obj),
		.out_address (o_addr)
	);

	assign m_axis_tdata = {6'b0, o_addr, o_obj, o_slab};
	assign in_xfer      = s_axis_tvalid && s_axis_tready;
	assign oom_out      = m_axis_tvalid && (m_axis_tuser == ST_OOM);

	`SOA_ASSERT(a_ready_div, clk, arst_n, !(s_axis_tready && stat.div_busy), "ready while busy")
	`SOA_ASSERT(a_oom_zero, clk, arst_n, !oom_out || (m_axis_tdata == '0), "oom result not zero")
	`SOA_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_xfer, !s_axis_tready && !cfg_ready, "ready")

endmodule

// File: tb/sv/slab_alloc_checker.sv
`timescale 1ns / 100ps

module slab_alloc_checker
	import soa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [11:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic              status;
		logic [SLAB_W-1:0] slab;
		logic [OBJ_W-1:0]  obj;
		logic [ADDR_W-1:0] addr;
	} alloc_result_t;

	alloc_result_t      expected_results[$];
	logic [SIZE_W-1:0]  obj_size;
	logic               claimed[SLABS];
	int                 free_cnt[SLABS];
	int                 rank[SLABS];
	logic [OBJ_W-1:0]   stack_mem[SLABS][MAX_OBJECTS];

	function automatic int objs_per_slab();
		int d;
		int n;
		d = int'(obj_size) + HEADER_BYTES;
		if (d == 0)
			d = 1;
		n = SLAB_BYTES / d;
		return (n > MAX_OBJECTS) ? MAX_OBJECTS : n;
	endfunction

	function automatic logic [ADDR_W-1:0] obj_addr(int s, int o);
		return ADDR_W'(s * SLAB_BYTES + o * (int'(obj_size) + HEADER_BYTES) + HEADER_BYTES);
	endfunction

	task automatic mark_recent(int s);
		int old;
		old = rank[s];
		for (int t = 0; t < SLABS; t++)
			if (rank[t] < old)
				rank[t]++;
		rank[s] = 0;
	endtask

	task automatic predict_item(logic cmd, int s, int o);
		alloc_result_t r;
		int n;
		int part;
		int whole;
		n = objs_per_slab();
		part = -1;
		whole = -1;
		if (cmd == CMD_FREE) begin
			if (s < SLABS && claimed[s] && o < n && free_cnt[s] < n) begin
				stack_mem[s][free_cnt[s]] = OBJ_W'(o);
				free_cnt[s]++;
				mark_recent(s);
			end
			r = '{ST_DONE, SLAB_W'(s), OBJ_W'(o), obj_addr(s, o)};
		end else begin
			if (n != 0) begin
				for (int t = 0; t < SLABS; t++) begin
					if (!claimed[t] || free_cnt[t] == 0)
						continue;
					if (free_cnt[t] < n) begin
						if (part < 0 || rank[t] < rank[part])
							part = t;
					end else if (whole < 0 || rank[t] < rank[whole]) begin
						whole = t;
					end
				end
				if (part < 0 && whole < 0) begin
					for (int t = 0; t < SLABS; t++) begin
						if (!claimed[t]) begin
							claimed[t] = 1'b1;
							for (int i = 0; i < n; i++)
								stack_mem[t][i] = OBJ_W'(i);
							free_cnt[t] = n;
							whole = t;
							break;
						end
					end
				end
			end
			if (part < 0 && whole < 0) begin
				r = '{ST_OOM, '0, '0, '0};
			end else begin
				s = (part >= 0) ? part : whole;
				free_cnt[s]--;
				o = int'(stack_mem[s][free_cnt[s]]);
				mark_recent(s);
				r = '{ST_DONE, SLAB_W'(s), OBJ_W'(o), obj_addr(s, o)};
			end
		end
		expected_results.push_back(r);
	endtask

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t got;
		alloc_result_t want;
		if (!arst_n) begin
			obj_size = OBJ_SIZE_RST;
			fail_count <= 0;
			expected_results.delete();
			for (int s = 0; s < SLABS; s++) begin
				claimed[s] = 1'b0;
				free_cnt[s] = 0;
				rank[s] = s;
			end
		end else begin
			// compare first: a result never stems from an item taken on the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[10:3],
					m_axis_tdata[25:11]};
				if (expected_results.size() == 0) begin
					$error("unexpected result transfer %h", m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						fail_count <= fail_count + 1;
						if (got.status !== want.status)
							$error("status exp %0d got %0d", want.status, got.status);
						if (got.slab !== want.slab)
							$error("out_slab exp %0d got %0d", want.slab, got.slab);
						if (got.obj !== want.obj)
							$error("out_object exp %0d got %0d", want.obj, got.obj);
						if (got.addr !== want.addr)
							$error("object_address exp %0d got %0d", want.addr, got.addr);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_item(s_axis_tuser, int'(s_axis_tdata[2:0]), int'(s_axis_tdata[10:3]));
			if (cfg_valid && cfg_ready)
				obj_size = cfg_data;
		end
	end

endmodule

// File: tb/sv/tb_slab_object_allocator_unit.sv
`timescale 1ns / 100ps

module tb_slab_object_allocator_unit;
	import soa_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [11:0] cfg_data;
	int          fail_count;
	int          pending;
	int          cycles;
	int          send_idle;
	int          recv_stall;

	slab_object_allocator_unit dut (.*);

	slab_alloc_checker chk (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("slab_object_allocator_unit: mismatch");
			$finish;
		end
	end

	// receiver backpressure at the current phase's rate
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall);

	// valid stays up after the transfer until the next item or an idle cycle replaces it
	task automatic send_item(logic cmd, logic [2:0] s, logic [7:0] o);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {5'd0, o, s};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (40)
			@(posedge clk);
	endtask

	task automatic write_size(logic [11:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// random traffic: mostly allocates; frees are mostly of plausible handles, some wild ones
	task automatic random_items(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 55)
				send_item(CMD_ALLOC, 3'($urandom), 8'($urandom));
			else if ($urandom_range(3) == 0)
				send_item(CMD_FREE, 3'($urandom), 8'($urandom));
			else
				send_item(CMD_FREE, 3'($urandom_range(3)), 8'($urandom_range(40)));
		end
	endtask

	initial begin
		logic [11:0] sizes[6];
		sizes = '{12'd1, 12'd2048, 12'd4095, 12'd40, 12'd0, 12'd200};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b1;
		cfg_valid = 1'b0;
		cfg_data = '0;
		cycles = 0;
		send_idle = 0;
		recv_stall = 0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default size, claims, ignored and double frees
		send_item(CMD_FREE, 3'd0, 8'd0);
		send_item(CMD_ALLOC, 3'd7, 8'hff);
		send_item(CMD_ALLOC, 3'd0, 8'd0);
		send_item(CMD_FREE, 3'd0, 8'd46);
		send_item(CMD_FREE, 3'd0, 8'd46);
		send_item(CMD_FREE, 3'd0, 8'd45);
		send_item(CMD_FREE, 3'd0, 8'd255);
		send_item(CMD_FREE, 3'd7, 8'd3);
		send_item(CMD_ALLOC, 3'd0, 8'd0);
		write_size(12'd2048);
		for (int i = 0; i < 10; i++)
			send_item(CMD_ALLOC, 3'd0, 8'd0);
		send_item(CMD_FREE, 3'd2, 8'd0);
		write_size(12'd4095);
		send_item(CMD_ALLOC, 3'd0, 8'd0);
		send_item(CMD_FREE, 3'd1, 8'd0);

		for (int p = 0; p < 12; p++) begin
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 46; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 46; end
				default: begin send_idle = 26; recv_stall = 26; end
			endcase
			write_size(sizes[p % 6]);
			random_items(145);
		end
		send_idle = 0;
		recv_stall = 0;
		drain();
		if (fail_count == 0)
			$display("slab_object_allocator_unit: match");
		else
			$display("slab_object_allocator_unit: mismatch");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/soa_pkg.sv
rtl/soa_div.sv
rtl/soa_ctrl.sv
rtl/soa_dp.sv
rtl/slab_object_allocator_unit.sv
tb/sv/slab_alloc_checker.sv
tb/sv/tb_slab_object_allocator_unit.sv
